FILE: rtl/rsip_pkg.sv
// ----------------------------------------------------------------------------
// rsip_pkg: shared types and constants for the radix string parser
// Beat payload structs, status codes, character codes and overflow limits.
// ----------------------------------------------------------------------------
`default_nettype none

package rsip_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StLoneSign = 3'd2,
    StInvalid  = 3'd3,
    StOverflow = 3'd4
  } status_e;

  // Input beat: one character of the string.
  typedef struct packed {
    logic [15:0] character;
    logic        last;
    logic        empty_string;
  } in_t;

  // Output beat: one parse result.
  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
  } out_t;

  // Character class, worked out ahead of the accumulate stage.
  typedef struct packed {
    logic       below_zero;
    logic       is_plus;
    logic       is_minus;
    logic       digit_ok;
    logic [5:0] digit;
  } chr_class_t;

  // Contents of the decode stage register.
  typedef struct packed {
    chr_class_t cls;
    logic       last;
    logic       empty_string;
  } stage_t;

  localparam logic [15:0] CharPlus   = 16'h002B;
  localparam logic [15:0] CharMinus  = 16'h002D;
  localparam logic [15:0] CharZero   = 16'h0030;
  localparam logic [15:0] CharNine   = 16'h0039;
  localparam logic [15:0] CharUpperA = 16'h0041;
  localparam logic [15:0] CharUpperZ = 16'h005A;
  localparam logic [15:0] CharLowerA = 16'h0061;
  localparam logic [15:0] CharLowerZ = 16'h007A;

  localparam logic [5:0] RadixMin   = 6'd2;
  localparam logic [5:0] RadixMax   = 6'd36;
  localparam logic [5:0] RadixReset = 6'd10;
  localparam logic [5:0] LetterBase = 6'd10;

  // Magnitude limits for positive and negative results.
  localparam logic [37:0] PosLimit = 38'h00_7FFF_FFFF;
  localparam logic [37:0] NegLimit = 38'h00_8000_0000;

endpackage

`default_nettype wire

FILE: rtl/radix_string_to_int_parser.sv
// ----------------------------------------------------------------------------
// radix_string_to_int_parser: signed integer parser, radix 2 to 36
// Streams one character per beat and returns one signed 32-bit result or a
// status on the last character of each string or on an empty-string beat.
// ----------------------------------------------------------------------------
// The block takes one character beat in every cycle unless the output stalls;
// a result passes the decode and output registers. The first register stage
// classifies the character against the radix; the second holds the running
// magnitude and does one 32 by 6 bit multiply, digit add and limit compare per
// character, which sets the one-character-per-cycle rate. The output register
// lets a new character enter while a result waits; the input stalls only when
// a result-bearing beat meets a full, stalled output. The radix register resets
// to 10 and is written through the configuration channel, always ready; the
// user writes it only while the block is idle; the block does not enforce it.
`default_nettype none

module radix_string_to_int_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output wire logic             in_ready_o,
  input  wire rsip_pkg::in_t    in_i,
  output wire logic             out_valid_o,
  input  wire logic             out_ready_i,
  output rsip_pkg::out_t        out_o,
  input  wire logic             cfg_valid_i,
  output wire logic             cfg_ready_o,
  input  wire logic [5:0]       cfg_radix_i
);

  logic [5:0]          radix_q;
  rsip_pkg::chr_class_t cls;

  logic                s1_valid_q, s1_valid_d;
  rsip_pkg::stage_t    s1_q;

  logic [31:0]         mag_q, mag_d;
  logic                neg_q, neg_d;
  logic                first_q, first_d;
  rsip_pkg::status_e   err_q, err_d;

  logic                out_valid_q, out_valid_d;
  rsip_pkg::out_t      out_q, out_d;

  logic                emits;
  logic                adv;
  logic                in_accept;

  logic [37:0]         prod;
  logic [37:0]         sum;
  logic [37:0]         limit;
  logic                ovf;

  logic                neg_n;
  logic [31:0]         mag_n;
  rsip_pkg::status_e   err_n;

  // Radix register, always ready for a write beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rsip_pkg::RadixReset;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  // Character classification ahead of the decode register.
  rsip_char_decode u_decode (
    .character_i (in_i.character),
    .radix_i     (radix_q),
    .cls_o       (cls)
  );

  // The decode stage drains unless it carries a result and the output is stuck.
  assign emits      = s1_q.last || s1_q.empty_string;
  assign adv        = s1_valid_q && (!emits || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.cls          <= cls;
      s1_q.last         <= in_i.last;
      s1_q.empty_string <= in_i.empty_string;
    end
  end

  // Multiply-add of the next digit and the overflow compare against the limit.
  assign prod  = 38'(mag_q) * 38'(radix_q);
  assign sum   = prod + 38'(s1_q.cls.digit);
  assign limit = neg_q ? rsip_pkg::NegLimit : rsip_pkg::PosLimit;
  assign ovf   = (sum > limit);

  // Accumulate stage: sign, sticky error, magnitude and the result beat.
  always_comb begin
    neg_n       = neg_q;
    mag_n       = mag_q;
    err_n       = err_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    first_d     = first_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (err_q == rsip_pkg::StOk) begin
      if (first_q && s1_q.cls.below_zero) begin
        if (s1_q.cls.is_minus) begin
          neg_n = 1'b1;
        end else if (!s1_q.cls.is_plus) begin
          err_n = rsip_pkg::StInvalid;
        end
        if ((err_n == rsip_pkg::StOk) && s1_q.last) begin
          err_n = rsip_pkg::StLoneSign;
        end
      end else if (!s1_q.cls.digit_ok) begin
        err_n = rsip_pkg::StInvalid;
      end else if (ovf) begin
        err_n = rsip_pkg::StOverflow;
      end else begin
        mag_n = sum[31:0];
      end
    end

    if (adv) begin
      if (s1_q.empty_string || s1_q.last) begin
        // Result beat, then the string state starts over.
        out_valid_d = 1'b1;
        mag_d       = '0;
        neg_d       = 1'b0;
        first_d     = 1'b1;
        err_d       = rsip_pkg::StOk;
        if (s1_q.empty_string) begin
          out_d.value  = '0;
          out_d.status = rsip_pkg::StEmpty;
        end else if (err_n != rsip_pkg::StOk) begin
          out_d.value  = '0;
          out_d.status = err_n;
        end else begin
          out_d.value  = neg_n ? $signed(~mag_n + 32'd1) : $signed(mag_n);
          out_d.status = rsip_pkg::StOk;
        end
      end else begin
        mag_d   = mag_n;
        neg_d   = neg_n;
        err_d   = err_n;
        first_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      first_q     <= 1'b1;
      err_q       <= rsip_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      first_q     <= first_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The magnitude never passes the limit of its sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mag_q <= 32'h8000_0000) && (neg_q || (mag_q <= 32'h7FFF_FFFF)))
    else $error("magnitude beyond limit");

  // A result beat leaves the string state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emits |=> first_q && !neg_q && (mag_q == '0) && (err_q == rsip_pkg::StOk))
    else $error("string state not cleared after result");

  // A result-bearing beat held against a stalled output stays in the stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && emits && out_valid_q && !out_ready_i |=> s1_valid_q && $stable(s1_q))
    else $error("result beat dropped under stall");

  // A non-ok status always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != rsip_pkg::StOk) |-> (out_q.value == '0))
    else $error("error status with nonzero value");

  // Input stalls only while the decode stage holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with empty stage");

endmodule

`default_nettype wire

FILE: rtl/rsip_char_decode.sv
// ----------------------------------------------------------------------------
// rsip_char_decode: character classifier
// Maps a character code to its digit value under the current radix and flags
// the sign characters and codes below '0'.
// ----------------------------------------------------------------------------
`default_nettype none

module rsip_char_decode (
  input  wire logic [15:0]         character_i,
  input  wire logic [5:0]          radix_i,
  output rsip_pkg::chr_class_t     cls_o
);

  logic [15:0] num_off;
  logic [15:0] upper_off;
  logic [15:0] lower_off;
  logic        is_num;
  logic        is_upper;
  logic        is_lower;
  logic        radix_ok;
  logic [5:0]  digit;
  logic        is_digit;

  assign num_off   = character_i - rsip_pkg::CharZero;
  assign upper_off = character_i - rsip_pkg::CharUpperA;
  assign lower_off = character_i - rsip_pkg::CharLowerA;

  assign is_num   = (character_i >= rsip_pkg::CharZero) && (character_i <= rsip_pkg::CharNine);
  assign is_upper = (character_i >= rsip_pkg::CharUpperA) &&
                    (character_i <= rsip_pkg::CharUpperZ);
  assign is_lower = (character_i >= rsip_pkg::CharLowerA) &&
                    (character_i <= rsip_pkg::CharLowerZ);

  // A radix outside 2..36 accepts no digit at all.
  assign radix_ok = (radix_i >= rsip_pkg::RadixMin) && (radix_i <= rsip_pkg::RadixMax);

  // Digit value from whichever character range matched.
  always_comb begin
    digit    = '0;
    is_digit = 1'b0;
    if (is_num) begin
      digit    = num_off[5:0];
      is_digit = 1'b1;
    end else if (is_upper) begin
      digit    = upper_off[5:0] + rsip_pkg::LetterBase;
      is_digit = 1'b1;
    end else if (is_lower) begin
      digit    = lower_off[5:0] + rsip_pkg::LetterBase;
      is_digit = 1'b1;
    end
  end

  assign cls_o.below_zero = (character_i < rsip_pkg::CharZero);
  assign cls_o.is_plus    = (character_i == rsip_pkg::CharPlus);
  assign cls_o.is_minus   = (character_i == rsip_pkg::CharMinus);
  assign cls_o.digit_ok   = is_digit && radix_ok && (digit < radix_i);
  assign cls_o.digit      = digit;

endmodule

`default_nettype wire
